// ===== src/frq_pkg.sv =====
// Shared types, constants and helpers for the quarter-turn frame rotator.
`default_nettype none

package frq_pkg;

    localparam int SIZE_W     = 9;   // width and height register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TURN_LEFT = 2'd0,
        CFG_ANGLE     = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] ANG_0   = 2'd0;
    localparam logic [1:0] ANG_90  = 2'd1;
    localparam logic [1:0] ANG_180 = 2'd2;
    localparam logic [1:0] ANG_270 = 2'd3;

    localparam logic DIR_RIGHT = 1'b0;
    localparam logic DIR_LEFT  = 1'b1;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_CW,
        MODE_CCW,
        MODE_HALF
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STORE,
        S_POS,
        S_MUL,
        S_ADD,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              row_end;
        logic              frame_end;
    } t_out_beat;

    typedef struct packed {
        logic capture;
        logic store_wr;
        logic pos_fix;
        logic mul_ld;
        logic addr_ld;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic in_kind;
        logic out_free;
    } t_stat;

    function automatic t_mode turn_mode(input logic left, input logic [1:0] ang);
        t_mode m;
        priority if (ang == ANG_0) begin
            m = MODE_NONE;
        end else if ((left == DIR_RIGHT && ang == ANG_90) ||
                     (left == DIR_LEFT && ang == ANG_270)) begin
            m = MODE_CW;
        end else if ((left == DIR_RIGHT && ang == ANG_270) ||
                     (left == DIR_LEFT && ang == ANG_90)) begin
            m = MODE_CCW;
        end else begin
            m = MODE_HALF;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/frq_in_if.sv =====
// Input channel: valid/ready handshake carrying one store or fetch beat.
`default_nettype none

interface frq_in_if
    import frq_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/frq_out_if.sv =====
// Output channel: valid/ready handshake carrying one fetched pixel beat.
`default_nettype none

interface frq_out_if
    import frq_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/frq_ctrl.sv =====
// Sequencer for the rotator: steps store and fetch beats through the datapath.
`default_nettype none

module frq_ctrl
    import frq_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_stat.in_kind == KIND_STORE) ? S_STORE : S_POS;
                end
            end
            S_STORE: n_state = S_IDLE;
            S_POS:   n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = S_READ;
            S_READ:  n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.store_wr = (r_state == S_STORE);
        o_cmd.pos_fix  = (r_state == S_POS);
        o_cmd.mul_ld   = (r_state == S_MUL);
        o_cmd.addr_ld  = (r_state == S_ADD);
        o_cmd.out_ld   = (r_state == S_OUT) && i_stat.out_free;
    end

endmodule

`default_nettype wire

// ===== src/frq_dp.sv =====
// Rotator datapath: config registers, frame store, address arithmetic, output register.
`default_nettype none

module frq_dp
    import frq_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_in_beat               i_in_data,
    input  wire                    i_out_ready,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    output logic                   o_out_valid,
    output t_out_beat              o_out_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * SIZE_W;
    localparam int CW     = ((AW > PROD_W) ? AW : PROD_W) + 1;
    localparam int W_LIM_I = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
    localparam int H_LIM_I = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
    localparam logic [SIZE_W-1:0] W_LIM = SIZE_W'(W_LIM_I);
    localparam logic [SIZE_W-1:0] H_LIM = SIZE_W'(H_LIM_I);
    localparam logic [SIZE_W-1:0] ONE   = SIZE_W'(1);

    // configuration
    logic              r_turn_left;
    logic [1:0]        r_angle;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_left <= DIR_RIGHT;
            r_angle     <= ANG_0;
            r_width     <= SIZE_W'(256);
            r_height    <= SIZE_W'(256);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TURN_LEFT: r_turn_left <= i_cfg_data[0];
                CFG_ANGLE:     r_angle     <= i_cfg_data[1:0];
                CFG_WIDTH:     r_width     <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg_data[SIZE_W-1:0];
                default:       r_angle     <= r_angle;
            endcase
        end
    end

    // clamp the sizes into the range the store can hold
    logic [SIZE_W-1:0] w_c, h_c, ow, oh;
    t_mode             mode;

    always_comb begin
        priority if (r_width == '0)  w_c = ONE;
        else if (r_width > W_LIM)    w_c = W_LIM;
        else                         w_c = r_width;
        priority if (r_height == '0) h_c = ONE;
        else if (r_height > H_LIM)   h_c = H_LIM;
        else                         h_c = r_height;
        mode = turn_mode(r_turn_left, r_angle);
        if (mode == MODE_CW || mode == MODE_CCW) begin
            ow = h_c;
            oh = w_c;
        end else begin
            ow = w_c;
            oh = h_c;
        end
    end

    // frame size, refreshed every cycle from the registers
    logic [PROD_W-1:0] r_total;

    always_ff @(posedge i_clk) begin
        r_total <= w_c * h_c;
    end

    // captured input beat
    logic [PIX_W-1:0] r_rgb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rgb <= {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
        end
    end

    // store write address with wrap
    logic [AW-1:0] r_cnt;
    logic [CW-1:0] cnt_x, total_x, wr_x, nxt_x;

    always_comb begin
        cnt_x   = CW'(r_cnt);
        total_x = CW'(r_total);
        wr_x    = (cnt_x >= total_x) ? '0 : cnt_x;
        nxt_x   = wr_x + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.store_wr) begin
            r_cnt <= (nxt_x >= total_x) ? '0 : AW'(nxt_x);
        end
    end

    // output position
    logic [SIZE_W-1:0] r_row, r_col;
    logic              row_end, frame_end;

    always_comb begin
        row_end   = (r_col == ow - ONE);
        frame_end = row_end && (r_row == oh - ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.pos_fix) begin
            if (r_row >= oh || r_col >= ow) begin
                r_row <= '0;
                r_col <= '0;
            end
        end else if (i_cmd.out_ld) begin
            priority if (frame_end) begin
                r_row <= '0;
                r_col <= '0;
            end else if (row_end) begin
                r_row <= r_row + ONE;
                r_col <= '0;
            end else begin
                r_col <= r_col + ONE;
            end
        end
    end

    // address: line index times width, plus offset in the line
    logic [SIZE_W-1:0] mul_a, mul_off;
    logic [PROD_W-1:0] r_prod;
    logic [SIZE_W-1:0] r_off;
    logic [AW-1:0]     r_addr;
    logic [PROD_W:0]   sum;

    always_comb begin
        unique case (mode)
            MODE_NONE: begin
                mul_a   = r_row;
                mul_off = r_col;
            end
            MODE_CW: begin
                mul_a   = h_c - ONE - r_col;
                mul_off = r_row;
            end
            MODE_CCW: begin
                mul_a   = r_col;
                mul_off = w_c - ONE - r_row;
            end
            default: begin
                mul_a   = h_c - ONE - r_row;
                mul_off = w_c - ONE - r_col;
            end
        endcase
        sum = (PROD_W+1)'(r_prod) + (PROD_W+1)'(r_off);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_ld) begin
            r_prod <= mul_a * w_c;
            r_off  <= mul_off;
        end
        if (i_cmd.addr_ld) begin
            r_addr <= AW'(sum);
        end
    end

    // frame store
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_mem[AW'(wr_x)] <= r_rgb;
        end
        r_rdata <= r_mem[r_addr];
    end

    // output register
    logic      r_out_valid;
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out.red_out   <= r_rdata[3*CHAN_W-1:2*CHAN_W];
            r_out.green_out <= r_rdata[2*CHAN_W-1:CHAN_W];
            r_out.blue_out  <= r_rdata[CHAN_W-1:0];
            r_out.row_end   <= row_end;
            r_out.frame_end <= frame_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
    assign o_stat.in_kind  = i_in_data.kind;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== src/frame_rotate_quarter_turn.sv =====
// Top level of the quarter-turn frame rotator: sequencer plus datapath.
// A fetch beat passes through position check, multiply, add, store read and output
//   load in turn; a store beat only writes the frame store. The sequencer takes no new
//   beat until it is back in idle.
// A full output register holds the sequencer in its last step until the beat is taken.
// Reset (synchronous, active low) clears the counters, sequencer, output valid flag
//   and config registers to their defaults; the frame store keeps its contents.
`default_nettype none

module frame_rotate_quarter_turn
    import frq_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    frq_in_if.sink                i_pix,
    frq_out_if.source             o_pix
);

    // Command and status between sequencer and datapath.
    t_cmd  cmd;
    t_stat stat;

    // Sequencer: owns input ready, steps one beat at a time.
    frq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_stat     (stat),
        .o_in_ready (i_pix.ready),
        .o_cmd      (cmd)
    );

    // Datapath: registers, frame store, address maths and the output beat.
    frq_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_pix.data),
        .i_out_ready (o_pix.ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_pix.valid),
        .o_out_data  (o_pix.data)
    );

endmodule

`default_nettype wire

// ===== src/frq_checker.sv =====
// Port-level checks for the rotator, bound to the top level.
`default_nettype none

module frq_checker
    import frq_pkg::*;
(
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_in_kind,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_row_end,
    input wire i_frame_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped before it was taken");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_frame_end || i_row_end))
        else $error("frame end without row end");

    a_store_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == KIND_STORE) && !i_out_valid
        |=> !i_out_valid)
        else $error("store beat produced an output beat");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a beat is in progress");

endmodule

bind frame_rotate_quarter_turn frq_checker u_frq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_kind   (i_pix.data.kind),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_row_end   (o_pix.data.row_end),
    .i_frame_end (o_pix.data.frame_end)
);

`default_nettype wire

// ===== bench/frame_rotate_quarter_turn_tb.sv =====
// Self-checking bench for the quarter-turn frame rotator: stores, fetches and checks turned pixels.
`timescale 1ns / 1ps

module frame_rotate_quarter_turn_tb;
    import frq_pkg::*;

    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int STORE_DEPTH = MAX_W * MAX_H;
    localparam int STALL_LIMIT = 2000;   // cycles without any beat before giving up
    localparam int SETTLE_CYC  = 12;     // margin for a beat still in flight in the block
    localparam int STAGE_BEATS = 20;
    localparam int LARGE_READS = 16;

    // Shadow of the frame store and the read/write counters; holds the pixels
    // still owed by the block, oldest first.
    class pixel_scoreboard;
        bit [PIX_W-1:0]      pixels [0:STORE_DEPTH-1];
        bit                  filled [0:STORE_DEPTH-1];
        int unsigned         store_ptr;
        int unsigned         row_pos;
        int unsigned         col_pos;
        bit                  left_turn;
        bit [1:0]            angle;
        bit [SIZE_W-1:0]     width_reg;
        bit [SIZE_W-1:0]     height_reg;
        t_out_beat           expected_q[$];
        int                  errors;

        function new();
            store_ptr  = 0;
            row_pos    = 0;
            col_pos    = 0;
            left_turn  = DIR_RIGHT;
            angle      = ANG_0;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            errors     = 0;
        endfunction

        function int unsigned clamp(bit [SIZE_W-1:0] v, int unsigned lim);
            if (v == 0) return 1;
            if (v > lim) return lim;
            return v;
        endfunction

        function int unsigned frame_size();
            return clamp(width_reg, MAX_W) * clamp(height_reg, MAX_H);
        endfunction

        function t_mode turn();
            if (angle == ANG_0) return MODE_NONE;
            if (angle == ANG_180) return MODE_HALF;
            if ((angle == ANG_90) == (left_turn == DIR_RIGHT)) return MODE_CW;
            return MODE_CCW;
        endfunction

        // Output position after the restart rule, the output frame shape, and
        // the raster address that position reads.
        function int unsigned source_addr(output int unsigned row, output int unsigned col,
                                          output int unsigned out_w, output int unsigned out_h);
            int unsigned w;
            int unsigned h;
            t_mode       m;
            w = clamp(width_reg, MAX_W);
            h = clamp(height_reg, MAX_H);
            m = turn();
            if (m == MODE_CW || m == MODE_CCW) begin
                out_w = h;
                out_h = w;
            end else begin
                out_w = w;
                out_h = h;
            end
            row = row_pos;
            col = col_pos;
            if (row >= out_h || col >= out_w) begin
                row = 0;
                col = 0;
            end
            case (m)
                MODE_NONE: return row * w + col;
                MODE_CW:   return (h - 1 - col) * w + row;
                MODE_CCW:  return col * w + (w - 1 - row);
                default:   return (h - 1 - row) * w + (w - 1 - col);
            endcase
        endfunction

        function bit fetch_safe();
            int unsigned r;
            int unsigned c;
            int unsigned ow;
            int unsigned oh;
            return filled[source_addr(r, c, ow, oh)];
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_TURN_LEFT: left_turn  = v[0];
                CFG_ANGLE:     angle      = v[1:0];
                CFG_WIDTH:     width_reg  = v;
                default:       height_reg = v;
            endcase
        endfunction

        function void note_input(t_in_beat b);
            int unsigned total;
            int unsigned addr;
            int unsigned r;
            int unsigned c;
            int unsigned ow;
            int unsigned oh;
            t_out_beat   e;
            total = frame_size();
            if (b.kind == KIND_STORE) begin
                if (store_ptr >= total) store_ptr = 0;
                pixels[store_ptr] = {b.red_in, b.green_in, b.blue_in};
                filled[store_ptr] = 1'b1;
                store_ptr++;
                if (store_ptr >= total) store_ptr = 0;
            end else begin
                addr = source_addr(r, c, ow, oh);
                {e.red_out, e.green_out, e.blue_out} = pixels[addr];
                e.row_end   = (c == ow - 1);
                e.frame_end = e.row_end && (r == oh - 1);
                expected_q.insert(expected_q.size(), e);
                if (e.frame_end) begin
                    row_pos = 0;
                    col_pos = 0;
                end else if (e.row_end) begin
                    row_pos = r + 1;
                    col_pos = 0;
                end else begin
                    row_pos = r;
                    col_pos = c + 1;
                end
            end
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: pixel beat with none expected, actual %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            compare_field("red_out",   e.red_out,   got.red_out);
            compare_field("green_out", e.green_out, got.green_out);
            compare_field("blue_out",  e.blue_out,  got.blue_out);
            compare_field("row_end",   e.row_end,   got.row_end);
            compare_field("frame_end", e.frame_end, got.frame_end);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frq_in_if  pix_in ();
    frq_out_if pix_out ();

    frame_rotate_quarter_turn #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    pixel_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int beat_count;
    int stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Drop ready at random on the receiving side; at zero the sink never stalls.
    always @(posedge i_clk) begin
        pix_out.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check every pixel beat the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready) sb.check_result(pix_out.data);
    end

    // Abort the run when neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_in_beat rand_beat(logic kind);
        t_in_beat b;
        b.kind     = kind;
        b.red_in   = 8'($urandom_range(0, 255));
        b.green_in = 8'($urandom_range(0, 255));
        b.blue_in  = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Mostly small frame sides, now and then zero or just above the usual range.
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return SIZE_W'($urandom_range(7, 9));
        return SIZE_W'($urandom_range(1, 6));
    endfunction

    // Present one beat, idling first at the sender's rate, and hold it until
    // taken. Valid stays high into the next beat unless an idle cycle follows.
    task automatic send_beat(input t_in_beat b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data  <= b;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        sb.note_input(b);
        beat_count++;
    endtask

    // Never read a store entry that was not written: top up with stores until
    // the pixel the next fetch reads is known.
    task automatic fetch_pixel();
        while (!sb.fetch_safe()) send_beat(rand_beat(KIND_STORE));
        send_beat(rand_beat(KIND_FETCH));
    endtask

    // Wait until every owed pixel has come back, then let a store in flight finish.
    task automatic settle();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write the selected registers back to back, only once the block is idle.
    task automatic program_regs(input bit [3:0] sel, input logic tl, input logic [1:0] ang,
                                input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        int                    i;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] v;
        settle();
        for (i = 0; i < 4; i++) begin
            if (sel[i]) begin
                idx = t_cfg_idx'(i);
                case (idx)
                    CFG_TURN_LEFT: v = {8'd0, tl};
                    CFG_ANGLE:     v = {7'd0, ang};
                    CFG_WIDTH:     v = w;
                    default:       v = h;
                endcase
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= idx;
                i_cfg_data <= v;
                sb.write_reg(idx, v);
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        t_in_beat b;
        int       i;
        int       a;
        int       d;
        // Zero width acts as one: a single-pixel frame, fetched past its end.
        program_regs(4'b1111, DIR_RIGHT, ANG_0, 9'd0, 9'd1);
        b = rand_beat(KIND_STORE);
        {b.red_in, b.green_in, b.blue_in} = 24'hFF00FF;
        send_beat(b);
        fetch_pixel();
        fetch_pixel();
        // Store past the frame end lands back on the first pixel.
        b = rand_beat(KIND_STORE);
        {b.red_in, b.green_in, b.blue_in} = 24'h00FF00;
        send_beat(b);
        fetch_pixel();
        // A 3x2 frame with all-zero and all-one corners, then every turn.
        program_regs(4'b1100, DIR_RIGHT, ANG_0, 9'd3, 9'd2);
        for (i = 0; i < 6; i++) begin
            b = rand_beat(KIND_STORE);
            if (i == 0) {b.red_in, b.green_in, b.blue_in} = '0;
            if (i == 5) {b.red_in, b.green_in, b.blue_in} = '1;
            send_beat(b);
        end
        // The position carries across turns, so some changes leave it outside
        // the new output frame and force a restart.
        for (a = 0; a < 4; a++) begin
            for (d = 0; d < 2; d++) begin
                program_regs(4'b0011, d[0], a[1:0], '0, '0);
                fetch_pixel();
                fetch_pixel();
            end
        end
    endtask

    // Random reconfigure, then mostly a whole frame stored and read back with
    // some wrap, otherwise a short jumble of stores and fetches.
    task automatic run_stage(input int quota);
        int first;
        int total;
        first = beat_count;
        while (beat_count - first < quota) begin
            program_regs(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)), pick_size(), pick_size());
            total = sb.frame_size();
            if ($urandom_range(0, 9) < 7) begin
                repeat (total) send_beat(rand_beat(KIND_STORE));
                repeat (total + $urandom_range(0, 2)) fetch_pixel();
            end else begin
                repeat ($urandom_range(4, 20)) begin
                    if ($urandom_range(0, 1)) fetch_pixel();
                    else send_beat(rand_beat(KIND_STORE));
                end
            end
        end
    endtask

    // Largest sides: one full 256-pixel row stored and partly read back, then
    // the same pixels partly read as a 256-pixel column, with out-of-range
    // sizes clamped.
    task automatic run_large();
        program_regs(4'b1111, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     $urandom_range(0, 1) ? 9'd256 : 9'd511,
                     $urandom_range(0, 1) ? 9'd0 : 9'd1);
        repeat (MAX_W) send_beat(rand_beat(KIND_STORE));
        repeat (LARGE_READS) fetch_pixel();
        program_regs(4'b1111, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     $urandom_range(0, 1) ? 9'd0 : 9'd1,
                     $urandom_range(0, 1) ? 9'd256 : 9'd300);
        repeat (LARGE_READS) fetch_pixel();
    endtask

    initial begin
        sb           = new();
        tx_idle_pct  = 36;
        rx_idle_pct  = 77;
        beat_count   = 0;
        stall_cycles = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        pix_in.valid = 1'b0;
        pix_in.data  = '0;
        pix_out.ready = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Slow sender, very slow receiver.
        run_directed();
        run_stage(STAGE_BEATS);
        // Swap the idle rates.
        tx_idle_pct = 77;
        rx_idle_pct = 36;
        run_stage(STAGE_BEATS);
        // Full rate on both sides, including the largest frames.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_stage(STAGE_BEATS);
        run_large();

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/frq_pkg.sv
src/frq_in_if.sv
src/frq_out_if.sv
src/frq_ctrl.sv
src/frq_dp.sv
src/frame_rotate_quarter_turn.sv
src/frq_checker.sv
bench/frame_rotate_quarter_turn_tb.sv
